[rtl/tks_pkg.sv]
// Shared types, widths and codes for the top-k score selector.
// No dependencies; every other file refers to this package by scoped names.
package tks_pkg;

    localparam int MAX_KEPT     = 16;
    localparam int SCORE_BITS   = 16;
    localparam int ID_BITS      = 31;
    localparam int AGE_BITS     = 32;
    localparam int NCOUNT_BITS  = 5;
    localparam int IDX_BITS     = $clog2(MAX_KEPT);
    localparam int CNT_BITS     = $clog2(MAX_KEPT + 1);
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 31;
    localparam int TDATA_BITS   = ((ID_BITS + SCORE_BITS + 7) / 8) * 8;

    typedef logic [ID_BITS-1:0]           user_t;
    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef logic [AGE_BITS-1:0]          age_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_NEIGHBOR_COUNT = 2'd0,
        REG_KEEP_SMALLEST  = 2'd1,
        REG_QUERY_USER     = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFER,
        ST_SCAN,
        ST_JUDGE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic first;
        logic step;
        logic judge;
    } scan_ctrl_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        user_t user;
        score_t score;
        age_t  age;
    } slot_wr_t;

endpackage

[rtl/tks_slot_store.sv]
// Slot register file: one write port, one read port addressed by the sequencer pointer.
// Depends on tks_pkg.
module tks_slot_store (
    input  logic               aclk,
    input  tks_pkg::slot_wr_t  wr,
    input  tks_pkg::idx_t      raddr,
    output tks_pkg::user_t     rd_user,
    output tks_pkg::score_t    rd_score,
    output tks_pkg::age_t      rd_age
);

    tks_pkg::user_t  user_reg  [tks_pkg::MAX_KEPT];
    tks_pkg::score_t score_reg [tks_pkg::MAX_KEPT];
    tks_pkg::age_t   age_reg   [tks_pkg::MAX_KEPT];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            user_reg[wr.addr]  <= wr.user;
            score_reg[wr.addr] <= wr.score;
            age_reg[wr.addr]   <= wr.age;
        end
    end

    assign rd_user  = user_reg[raddr];
    assign rd_score = score_reg[raddr];
    assign rd_age   = age_reg[raddr];

endmodule

[rtl/tks_worst_scan.sv]
// Shared score comparator with the running worst-entry tracker.
// Depends on tks_pkg.
module tks_worst_scan (
    input  logic                aclk,
    input  tks_pkg::scan_ctrl_t ctrl,
    input  logic                keep_smallest,
    input  tks_pkg::score_t     cand_score,
    input  tks_pkg::idx_t       rd_idx,
    input  tks_pkg::score_t     rd_score,
    input  tks_pkg::age_t       rd_age,
    output tks_pkg::idx_t       worst_idx,
    output logic                cand_wins
);

    tks_pkg::idx_t   worst_idx_reg,   worst_idx_next;
    tks_pkg::score_t worst_score_reg, worst_score_next;
    tks_pkg::age_t   worst_age_reg,   worst_age_next;

    tks_pkg::score_t op_a;
    tks_pkg::score_t op_b;
    logic            a_better;
    logic            take;

    always_comb begin
        op_a = ctrl.judge ? cand_score : worst_score_reg;
        op_b = ctrl.judge ? worst_score_reg : rd_score;
        a_better = keep_smallest ? (op_a < op_b) : (op_a > op_b);
    end

    always_comb begin
        take = ctrl.first || a_better ||
               ((rd_score == worst_score_reg) && (rd_age > worst_age_reg));
        worst_idx_next   = worst_idx_reg;
        worst_score_next = worst_score_reg;
        worst_age_next   = worst_age_reg;
        if (ctrl.step && take) begin
            worst_idx_next   = rd_idx;
            worst_score_next = rd_score;
            worst_age_next   = rd_age;
        end
    end

    always_ff @(posedge aclk) begin
        worst_idx_reg   <= worst_idx_next;
        worst_score_reg <= worst_score_next;
        worst_age_reg   <= worst_age_next;
    end

    assign worst_idx = worst_idx_reg;
    assign cand_wins = ctrl.judge && a_better;

endmodule

[rtl/top_k_score_selector_core.sv]
// Top level of the top-k score selector: sequencer, configuration and stream ports.
// Depends on tks_pkg, tks_slot_store and tks_worst_scan.
//
// Usage:
//   Candidates enter on the s_ channel, one transaction each; s_tlast marks the
//   end of a scan. Each scan yields one run of result transactions on the m_
//   channel, one per held entry in slot order, m_tlast on the final one; an
//   empty store yields no run. Registers are written through cfg_wr_en,
//   cfg_addr and cfg_wdata; the user must write them only while the block is
//   idle, as the block does not enforce it. Timing: s_tready drops for the
//   whole of one item. An item that is skipped or fills a free slot needs no
//   scan; one that must contest a full store passes each held slot in turn
//   through the single shared comparator and is then judged. An end-of-scan
//   item emits the held entries, at most 16, paced by the single slot
//   read port and the m_ handshake. The output register holds a result until
//   taken; a stall on m_tready stalls the emit sequence and, with it, s_tready.
//   Reset (aresetn low, synchronous) empties the store, clears the output
//   valid flag and loads the registers with k = 10, nearest mode, query id 0.
module top_k_score_selector_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tks_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [tks_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tks_pkg::TDATA_BITS-1:0]    s_tdata,   // user_id, score, zero pad
    input  logic                              s_tuser,   // has_candidate
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tks_pkg::TDATA_BITS-1:0]    m_tdata,   // kept_user, kept_score, zero pad
    output logic                              m_tlast
);

    tks_pkg::state_t state_reg, state_next;

    logic [tks_pkg::NCOUNT_BITS-1:0] ncount_reg;
    logic                            keep_smallest_reg;
    tks_pkg::user_t                  query_user_reg;

    tks_pkg::user_t  cand_user_reg;
    tks_pkg::score_t cand_score_reg;
    logic            has_reg;
    logic            eos_reg;

    tks_pkg::cnt_t fill_reg,    fill_next;
    tks_pkg::age_t arrival_reg, arrival_next;
    tks_pkg::idx_t ptr_reg,     ptr_next;

    logic           m_valid_reg, m_valid_next;
    tks_pkg::user_t m_user_reg,  m_user_next;
    tks_pkg::score_t m_score_reg, m_score_next;
    logic           m_last_reg,  m_last_next;

    tks_pkg::slot_wr_t   wr;
    tks_pkg::scan_ctrl_t ctrl;
    tks_pkg::user_t      rd_user;
    tks_pkg::score_t     rd_score;
    tks_pkg::age_t       rd_age;
    tks_pkg::idx_t       worst_idx;
    logic                cand_wins;

    tks_pkg::cnt_t k_sat;
    tks_pkg::cnt_t fill_m1;
    logic          cand_ok;
    logic          at_last_slot;
    logic          s_accept;
    logic          out_free;

    assign s_tready = (state_reg == tks_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign k_sat   = (ncount_reg > tks_pkg::NCOUNT_BITS'(tks_pkg::MAX_KEPT)) ?
                     tks_pkg::CNT_BITS'(tks_pkg::MAX_KEPT) : tks_pkg::CNT_BITS'(ncount_reg);
    assign fill_m1 = fill_reg - tks_pkg::CNT_BITS'(1);
    assign cand_ok = has_reg && (cand_user_reg != query_user_reg);
    assign at_last_slot = (tks_pkg::CNT_BITS'(ptr_reg) == fill_m1);

    tks_slot_store u_store (
        .aclk     (aclk),
        .wr       (wr),
        .raddr    (ptr_reg),
        .rd_user  (rd_user),
        .rd_score (rd_score),
        .rd_age   (rd_age)
    );

    tks_worst_scan u_scan (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .keep_smallest (keep_smallest_reg),
        .cand_score    (cand_score_reg),
        .rd_idx        (ptr_reg),
        .rd_score      (rd_score),
        .rd_age        (rd_age),
        .worst_idx     (worst_idx),
        .cand_wins     (cand_wins)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tks_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = tks_pkg::ST_OFFER;
                end
            end
            tks_pkg::ST_OFFER: begin
                if (cand_ok && (fill_reg < k_sat)) begin
                    state_next = eos_reg ? tks_pkg::ST_EMIT : tks_pkg::ST_IDLE;
                end else if (cand_ok && (fill_reg != '0)) begin
                    state_next = tks_pkg::ST_SCAN;
                end else if (eos_reg && (fill_reg != '0)) begin
                    state_next = tks_pkg::ST_EMIT;
                end else begin
                    state_next = tks_pkg::ST_IDLE;
                end
            end
            tks_pkg::ST_SCAN: begin
                if (at_last_slot) begin
                    state_next = tks_pkg::ST_JUDGE;
                end
            end
            tks_pkg::ST_JUDGE: begin
                state_next = eos_reg ? tks_pkg::ST_EMIT : tks_pkg::ST_IDLE;
            end
            tks_pkg::ST_EMIT: begin
                if (out_free && at_last_slot) begin
                    state_next = tks_pkg::ST_IDLE;
                end
            end
            default: state_next = tks_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        fill_next    = fill_reg;
        arrival_next = arrival_reg;
        ptr_next     = ptr_reg;
        ctrl         = '0;
        wr.en        = 1'b0;
        wr.addr      = worst_idx;
        wr.user      = cand_user_reg;
        wr.score     = cand_score_reg;
        wr.age       = arrival_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_user_next  = m_user_reg;
        m_score_next = m_score_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            tks_pkg::ST_IDLE: begin
                ptr_next = '0;
            end
            tks_pkg::ST_OFFER: begin
                ptr_next = '0;
                if (cand_ok && (fill_reg < k_sat)) begin
                    wr.en        = 1'b1;
                    wr.addr      = tks_pkg::IDX_BITS'(fill_reg);
                    fill_next    = fill_reg + tks_pkg::CNT_BITS'(1);
                    arrival_next = arrival_reg + tks_pkg::AGE_BITS'(1);
                end else if (eos_reg && (fill_reg == '0)) begin
                    fill_next    = '0;
                    arrival_next = '0;
                end
            end
            tks_pkg::ST_SCAN: begin
                ctrl.step  = 1'b1;
                ctrl.first = (ptr_reg == '0);
                ptr_next   = ptr_reg + tks_pkg::IDX_BITS'(1);
            end
            tks_pkg::ST_JUDGE: begin
                ctrl.judge = 1'b1;
                ptr_next   = '0;
                if (cand_wins) begin
                    wr.en        = 1'b1;
                    arrival_next = arrival_reg + tks_pkg::AGE_BITS'(1);
                end
            end
            tks_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = rd_user;
                    m_score_next = rd_score;
                    m_last_next  = at_last_slot;
                    ptr_next     = ptr_reg + tks_pkg::IDX_BITS'(1);
                    if (at_last_slot) begin
                        fill_next    = '0;
                        arrival_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= tks_pkg::ST_IDLE;
            ncount_reg        <= tks_pkg::NCOUNT_BITS'(10);
            keep_smallest_reg <= 1'b0;
            query_user_reg    <= '0;
            fill_reg          <= '0;
            arrival_reg       <= '0;
            ptr_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            arrival_reg <= arrival_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    tks_pkg::REG_NEIGHBOR_COUNT:
                        ncount_reg <= cfg_wdata[tks_pkg::NCOUNT_BITS-1:0];
                    tks_pkg::REG_KEEP_SMALLEST:
                        keep_smallest_reg <= cfg_wdata[0];
                    tks_pkg::REG_QUERY_USER:
                        query_user_reg <= cfg_wdata[tks_pkg::ID_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // hold the accepted transaction and the output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cand_user_reg  <= s_tdata[tks_pkg::ID_BITS-1:0];
            cand_score_reg <= s_tdata[tks_pkg::ID_BITS +: tks_pkg::SCORE_BITS];
            has_reg        <= s_tuser;
            eos_reg        <= s_tlast;
        end
        m_user_reg  <= m_user_next;
        m_score_reg <= m_score_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tks_pkg::TDATA_BITS'({m_score_reg, m_user_reg});
    assign m_tlast  = m_last_reg;

endmodule

[rtl/tks_checker.sv]
// Port-level checks for the top-k score selector, bound to the top level.
// Depends on tks_pkg and top_k_score_selector_core.
module tks_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tks_pkg::TDATA_BITS-1:0] m_tdata,
    input logic                           m_tlast
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during a run");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind top_k_score_selector_core tks_checker u_tks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for top_k_score_selector_core: directed and random scans,
// each result checked against an in-bench top-k predictor. Depends on tks_pkg and top_k_score_selector_core.
module tb_top;

    localparam int             SETTLE_CYCLES = 32;
    localparam int             CYCLE_LIMIT   = 400000;
    localparam int             RANDOM_ITEMS  = 260;
    localparam int             STEADY_ITEMS  = 40;
    localparam tks_pkg::user_t ID_MAX        = {tks_pkg::ID_BITS{1'b1}};

    typedef struct {
        tks_pkg::user_t  user;
        tks_pkg::score_t score;
        logic            last;
    } kept_entry_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [tks_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
    logic [tks_pkg::CFG_DATA_BITS-1:0] cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [tks_pkg::TDATA_BITS-1:0]    s_tdata;
    logic                              s_tuser;
    logic                              s_tlast;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [tks_pkg::TDATA_BITS-1:0]    m_tdata;
    logic                              m_tlast;

    top_k_score_selector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    int unsigned     keep_k;
    logic            farthest;
    tks_pkg::user_t  skip_user;
    tks_pkg::user_t  held_user [tks_pkg::MAX_KEPT];
    tks_pkg::score_t held_score[tks_pkg::MAX_KEPT];
    logic [31:0]     held_stamp[tks_pkg::MAX_KEPT];
    int              held_count;
    logic [31:0]     next_stamp;
    kept_entry_t     kept_expect[$];

    int mismatches = 0;
    int cycles     = 0;
    int items_sent = 0;
    bit idle_on    = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("top_k_score_selector_core verification failed");
            $finish;
        end
    end

    function automatic bit outranks(tks_pkg::score_t a, tks_pkg::score_t b);
        return farthest ? (a < b) : (a > b);
    endfunction

    function automatic void hold_entry(int slot, tks_pkg::user_t u, tks_pkg::score_t s);
        held_user[slot]  = u;
        held_score[slot] = s;
        held_stamp[slot] = next_stamp;
        next_stamp       = next_stamp + 32'd1;
    endfunction

    function automatic void offer_candidate(tks_pkg::user_t u, tks_pkg::score_t s);
        int limit;
        int worst;
        limit = (keep_k > tks_pkg::MAX_KEPT) ? tks_pkg::MAX_KEPT : int'(keep_k);
        worst = 0;
        if (held_count < limit) begin
            hold_entry(held_count, u, s);
            held_count++;
            return;
        end
        if (held_count == 0)
            return;
        for (int i = 1; i < held_count; i++) begin
            if (outranks(held_score[worst], held_score[i]) ||
                (held_score[i] == held_score[worst] && held_stamp[i] > held_stamp[worst]))
                worst = i;
        end
        if (outranks(s, held_score[worst]))
            hold_entry(worst, u, s);
    endfunction

    function automatic void predict_scan_item(bit has, tks_pkg::user_t u,
                                              tks_pkg::score_t s, bit eos);
        kept_entry_t e;
        if (has && u != skip_user)
            offer_candidate(u, s);
        if (!eos)
            return;
        for (int i = 0; i < held_count; i++) begin
            e.user  = held_user[i];
            e.score = held_score[i];
            e.last  = (i == held_count - 1);
            kept_expect = {kept_expect, e};
        end
        held_count = 0;
        next_stamp = '0;
    endfunction

    function automatic tks_pkg::user_t pick_user();
        case ($urandom_range(0, 7))
            0:       return skip_user;
            1:       return ID_MAX;
            2:       return '0;
            3, 4:    return tks_pkg::user_t'($urandom_range(0, 31));
            default: return tks_pkg::user_t'($urandom);
        endcase
    endfunction

    function automatic tks_pkg::score_t pick_score();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return tks_pkg::score_t'(int'($urandom_range(0, 8)) - 4);
            default: return tks_pkg::score_t'($urandom);
        endcase
    endfunction

    function automatic logic [tks_pkg::NCOUNT_BITS-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return 5'd17;
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic tks_pkg::user_t pick_query();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return ID_MAX;
            default: return tks_pkg::user_t'($urandom);
        endcase
    endfunction

    // result side: stall in random bursts while idling is on
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        kept_entry_t want;
        kept_entry_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.user  = m_tdata[tks_pkg::ID_BITS-1:0];
            got.score = m_tdata[tks_pkg::ID_BITS +: tks_pkg::SCORE_BITS];
            got.last  = m_tlast;
            if (kept_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: user %0d score %0d last %0b",
                             got.user, got.score, got.last);
            end else begin
                want = kept_expect.pop_front();
                if (got.user !== want.user || got.score !== want.score ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.user, want.score, want.last,
                                 got.user, got.score, got.last);
                end
            end
        end
    end

    task automatic send_item(bit has, tks_pkg::user_t u, tks_pkg::score_t s, bit eos);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tks_pkg::TDATA_BITS'({s, u});
        s_tuser  <= has;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_scan_item(has, u, s, eos);
        items_sent++;
    endtask

    // drop valid, drain expected results, then let the block finish its item
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (kept_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(logic [tks_pkg::NCOUNT_BITS-1:0] k, logic mode,
                                  tks_pkg::user_t q);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= tks_pkg::REG_NEIGHBOR_COUNT;
        cfg_wdata <= tks_pkg::CFG_DATA_BITS'(k);
        @(posedge aclk);
        cfg_addr  <= tks_pkg::REG_KEEP_SMALLEST;
        cfg_wdata <= tks_pkg::CFG_DATA_BITS'(mode);
        @(posedge aclk);
        cfg_addr  <= tks_pkg::REG_QUERY_USER;
        cfg_wdata <= tks_pkg::CFG_DATA_BITS'(q);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        keep_k    = k;
        farthest  = mode;
        skip_user = q;
    endtask

    task automatic run_scan(int len, bit with_end);
        for (int i = 0; i < len; i++) begin
            bit closing;
            bit has;
            closing = with_end && (i == len - 1);
            has     = closing ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) != 0);
            send_item(has, pick_user(), pick_score(), closing);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(1'b1, '0, 16'sd5, 1'b0);
        send_item(1'b1, ID_MAX, 16'sh7FFF, 1'b0);
        send_item(1'b1, 31'd1, 16'sh8000, 1'b0);
        send_item(1'b0, 31'd3, 16'sd9, 1'b0);
        send_item(1'b1, 31'd2, 16'sd0, 1'b1);
    endtask

    task automatic test_empty_scans();
        send_item(1'b0, 31'd5, 16'sd7, 1'b1);
        send_item(1'b1, skip_user, 16'sd9, 1'b1);
    endtask

    task automatic test_tie_eviction();
        settle_block();
        apply_settings(5'd2, 1'b0, '0);
        send_item(1'b1, 31'd20, 16'sd100, 1'b0);
        send_item(1'b1, 31'd21, 16'sd100, 1'b0);
        send_item(1'b1, 31'd22, 16'sd200, 1'b0);
        send_item(1'b1, 31'd23, 16'sd100, 1'b0);
        send_item(1'b0, '0, '0, 1'b1);
    endtask

    task automatic test_farthest_mode();
        settle_block();
        apply_settings(5'd1, 1'b1, ID_MAX);
        send_item(1'b1, ID_MAX, -16'sd3, 1'b0);
        send_item(1'b1, 31'd5, 16'sd10, 1'b0);
        send_item(1'b1, 31'd6, -16'sd5, 1'b0);
        send_item(1'b1, 31'd7, -16'sd5, 1'b1);
    endtask

    task automatic test_count_changes();
        settle_block();
        apply_settings(5'd3, 1'b0, '0);
        send_item(1'b1, 31'd10, 16'sd50, 1'b0);
        send_item(1'b1, 31'd11, -16'sd50, 1'b0);
        send_item(1'b1, 31'd12, 16'sd0, 1'b0);
        settle_block();
        apply_settings(5'd1, 1'b0, '0);
        send_item(1'b1, 31'd13, 16'sd20, 1'b0);
        send_item(1'b0, '0, '0, 1'b1);
        settle_block();
        apply_settings(5'd0, 1'b0, '0);
        send_item(1'b1, 31'd14, 16'sd1, 1'b0);
        send_item(1'b1, 31'd15, 16'sd2, 1'b1);
    endtask

    task automatic test_random_scans(int target);
        int len;
        while (items_sent < target) begin
            settle_block();
            apply_settings(pick_count(), 1'($urandom_range(0, 1)), pick_query());
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                if ($urandom_range(0, 3) == 0) begin
                    run_scan(len, 1'b0);
                    settle_block();
                    apply_settings(pick_count(), 1'($urandom_range(0, 1)), skip_user);
                end
                run_scan(len, 1'b1);
            end
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_scans(items_sent + STEADY_ITEMS);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= tks_pkg::REG_NEIGHBOR_COUNT;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        keep_k     = 10;
        farthest   = 1'b0;
        skip_user  = '0;
        held_count = 0;
        next_stamp = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_empty_scans();
        test_tie_eviction();
        test_farthest_mode();
        test_count_changes();
        test_random_scans(items_sent + RANDOM_ITEMS);
        test_steady_stream();

        settle_block();
        if (mismatches == 0 && kept_expect.size() == 0) begin
            $display("top_k_score_selector_core verification clean");
        end else begin
            $display("top_k_score_selector_core verification failed");
        end
        $finish;
    end

endmodule
